// ===== hdl/otn_pkg.sv =====
`default_nettype none
package otn_pkg;

   // telnet command and option codes
   localparam logic [7:0] C_IAC  = 8'hFF;
   localparam logic [7:0] C_DONT = 8'hFE;
   localparam logic [7:0] C_DO   = 8'hFD;
   localparam logic [7:0] C_WONT = 8'hFC;
   localparam logic [7:0] C_WILL = 8'hFB;
   localparam logic [7:0] C_SB   = 8'hFA;
   localparam logic [7:0] C_SE   = 8'hF0;

   localparam logic [7:0] OPT_ECHO  = 8'd1;
   localparam logic [7:0] OPT_TTYPE = 8'd24;
   localparam logic [7:0] OPT_EOR   = 8'd25;
   localparam logic [7:0] OPT_NAWS  = 8'd31;

   localparam logic [7:0] TTYPE_IS   = 8'd0;
   localparam logic [7:0] TTYPE_SEND = 8'd1;

   // parser states
   localparam logic [3:0] ST_DATA      = 4'd0;
   localparam logic [3:0] ST_IAC       = 4'd1;
   localparam logic [3:0] ST_WILL      = 4'd2;
   localparam logic [3:0] ST_WONT      = 4'd3;
   localparam logic [3:0] ST_DO        = 4'd4;
   localparam logic [3:0] ST_DONT      = 4'd5;
   localparam logic [3:0] ST_SB        = 4'd6;
   localparam logic [3:0] ST_SBIAC     = 4'd7;
   localparam logic [3:0] ST_SBDATA    = 4'd8;
   localparam logic [3:0] ST_SBDATAIAC = 4'd9;

   // option table field codes
   localparam logic [1:0] K_DO   = 2'd1;
   localparam logic [1:0] K_DONT = 2'd2;
   localparam logic [1:0] K_WILL = 2'd1;
   localparam logic [1:0] K_WONT = 2'd2;

   // event kinds from the parser
   localparam logic [1:0] EV_DATA  = 2'd0;
   localparam logic [1:0] EV_OPT   = 2'd1;
   localparam logic [1:0] EV_TTYPE = 2'd2;

   // reply burst kinds
   localparam logic [1:0] BK_DATA   = 2'd0;
   localparam logic [1:0] BK_ANSWER = 2'd1;
   localparam logic [1:0] BK_NAWS   = 2'd2;
   localparam logic [1:0] BK_TTYPE  = 2'd3;

   // index of the final byte of each burst kind; terminal-type adds the name length to its fixed part
   localparam logic [3:0] LAST_DATA   = 4'd0;
   localparam logic [3:0] LAST_ANSWER = 4'd2;
   localparam logic [3:0] LAST_NAWS   = 4'd11;
   localparam logic [3:0] TTYPE_FIXED = 4'd5;

   // register indexes
   localparam logic [1:0] CSR_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_NAME     = 2'd2;
   localparam logic [1:0] CSR_NAME_LEN = 2'd3;

   localparam int NAME_CHARS = 8;
   localparam int NAME_POS_W = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
   localparam int OPT_COUNT  = 256;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] cmd;
      logic [7:0] val;
   } otn_event_type;

   typedef struct packed {
      logic       we;
      logic [7:0] addr;
      logic [7:0] data;
   } otn_wr_type;

endpackage
`default_nettype wire

// ===== hdl/otn_table.sv =====
`default_nettype none
module otn_table (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rd_en,
   input  wire logic [7:0]         rd_addr,
   input  wire otn_pkg::otn_wr_type wr,
   output logic [7:0]              rd_data
);
   import otn_pkg::*;

   logic [7:0]           mem [OPT_COUNT];
   logic [OPT_COUNT-1:0] valid_ff;
   logic [7:0]           rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.we) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // entries never written since reset read as cleared
   assign rd_data = rd_valid_ff ? rd_data_ff : 8'd0;

endmodule
`default_nettype wire

// ===== hdl/otn_parser.sv =====
`default_nettype none
module otn_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,
   input  wire logic                  take,
   output logic                       ev_valid,
   output otn_pkg::otn_event_type     ev
);
   import otn_pkg::*;

   logic [3:0]    state_ff, state_in;
   logic [7:0]    sb_opt_ff, sb_opt_in;
   logic [7:0]    sb_first_ff, sb_first_in;
   logic          sb_has_ff, sb_has_in;
   logic          s1_valid_ff, s1_valid_in;
   otn_event_type s1_ev_ff, s1_ev_in;
   logic          accept;
   logic          new_ev;
   otn_event_type new_ev_data;
   logic          ttype_send;

   assign req_tready = !s1_valid_ff || take;
   assign accept     = req_tvalid && req_tready;
   assign ttype_send = (sb_opt_ff == OPT_TTYPE) && sb_has_ff && (sb_first_ff == TTYPE_SEND);

   always_comb begin
      state_in         = state_ff;
      sb_opt_in        = sb_opt_ff;
      sb_first_in      = sb_first_ff;
      sb_has_in        = sb_has_ff;
      new_ev           = 1'b0;
      new_ev_data.kind = EV_DATA;
      new_ev_data.cmd  = C_WILL;
      new_ev_data.val  = req_tdata;
      case (state_ff)
         ST_DATA: begin
            if (req_tdata == C_IAC) begin
               state_in = ST_IAC;
            end else begin
               new_ev = 1'b1;
            end
         end
         ST_IAC: begin
            state_in = ST_DATA;
            case (req_tdata)
               C_IAC:  new_ev = 1'b1;
               C_WILL: state_in = ST_WILL;
               C_WONT: state_in = ST_WONT;
               C_DO:   state_in = ST_DO;
               C_DONT: state_in = ST_DONT;
               C_SB: begin
                  state_in  = ST_SB;
                  sb_has_in = 1'b0;
               end
               default: state_in = ST_DATA;
            endcase
         end
         ST_WILL, ST_WONT, ST_DO, ST_DONT: begin
            new_ev           = 1'b1;
            new_ev_data.kind = EV_OPT;
            case (state_ff)
               ST_WILL: new_ev_data.cmd = C_WILL;
               ST_WONT: new_ev_data.cmd = C_WONT;
               ST_DO:   new_ev_data.cmd = C_DO;
               default: new_ev_data.cmd = C_DONT;
            endcase
            state_in = ST_DATA;
         end
         ST_SB: begin
            if (req_tdata == C_IAC) begin
               state_in = ST_SBIAC;
            end else begin
               sb_opt_in = req_tdata;
               sb_has_in = 1'b0;
               state_in  = ST_SBDATA;
            end
         end
         ST_SBIAC: begin
            if (req_tdata == C_IAC) begin
               sb_opt_in = C_IAC;
               sb_has_in = 1'b0;
               state_in  = ST_SBDATA;
            end else begin
               state_in = ST_DATA;
            end
         end
         ST_SBDATA: begin
            if (req_tdata == C_IAC) begin
               state_in = ST_SBDATAIAC;
            end else if (!sb_has_ff) begin
               sb_first_in = req_tdata;
               sb_has_in   = 1'b1;
            end
         end
         ST_SBDATAIAC: begin
            case (req_tdata)
               C_IAC: begin
                  if (!sb_has_ff) begin
                     sb_first_in = C_IAC;
                     sb_has_in   = 1'b1;
                  end
                  state_in = ST_SBDATA;
               end
               C_SE: begin
                  new_ev           = ttype_send;
                  new_ev_data.kind = EV_TTYPE;
                  sb_opt_in        = 8'd0;
                  state_in         = ST_DATA;
               end
               C_SB: begin
                  new_ev           = ttype_send;
                  new_ev_data.kind = EV_TTYPE;
                  state_in         = ST_SB;
               end
               default: state_in = ST_DATA;
            endcase
         end
         default: state_in = ST_DATA;
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !take;
      s1_ev_in    = s1_ev_ff;
      if (accept) begin
         s1_valid_in = new_ev;
         s1_ev_in    = new_ev_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_DATA;
         sb_opt_ff   <= 8'd0;
         sb_first_ff <= 8'd0;
         sb_has_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff    <= state_in;
            sb_opt_ff   <= sb_opt_in;
            sb_first_ff <= sb_first_in;
            sb_has_ff   <= sb_has_in;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ev_ff <= s1_ev_in;
   end

   assign ev_valid = s1_valid_ff;
   assign ev       = s1_ev_ff;

endmodule
`default_nettype wire

// ===== hdl/otn_reply.sv =====
`default_nettype none
module otn_reply (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   ev_valid,
   input  wire otn_pkg::otn_event_type ev,
   output logic                        take,
   input  wire logic [7:0]             tbl_rd_data,
   output otn_pkg::otn_wr_type         tbl_wr,
   input  wire logic [15:0]            window_width,
   input  wire logic [15:0]            window_height,
   input  wire logic [63:0]            term_name,
   input  wire logic [3:0]             term_name_len,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);
   import otn_pkg::*;

   logic                  busy_ff, busy_in;
   logic [1:0]            kind_ff, kind_in;
   logic [3:0]            idx_ff, idx_in;
   logic [3:0]            last_ff, last_in;
   logic [7:0]            cmd_ff, cmd_in;
   logic [7:0]            val_ff, val_in;

   logic                  grp_b;
   logic                  naws;
   logic [7:0]            reply_cmd;
   logic [1:0]            sent_code;
   logic [1:0]            got_code;
   logic [3:0]            nib_new;
   logic [3:0]            nib_old;
   logic                  send;
   logic                  produces;
   logic                  done;
   logic                  free;
   logic [3:0]            name_cnt;
   logic [3:0]            name_pos;
   logic [NAME_POS_W-1:0] name_sel;

   // table answer decision on the entry read at the option byte's transfer
   always_comb begin
      grp_b     = 1'b0;
      naws      = 1'b0;
      reply_cmd = C_DONT;
      sent_code = K_DONT;
      got_code  = K_WILL;
      case (ev.cmd)
         C_WILL: begin
            if (ev.val inside {OPT_ECHO, OPT_EOR}) begin
               reply_cmd = C_DO;
               sent_code = K_DO;
            end
         end
         C_WONT: begin
            got_code = K_WONT;
         end
         C_DO: begin
            grp_b    = 1'b1;
            got_code = K_DO;
            naws     = (ev.val == OPT_NAWS);
            if (ev.val inside {OPT_TTYPE, OPT_NAWS}) begin
               reply_cmd = C_WILL;
               sent_code = K_WILL;
            end else begin
               reply_cmd = C_WONT;
               sent_code = K_WONT;
            end
         end
         default: begin
            grp_b     = 1'b1;
            reply_cmd = C_WONT;
            sent_code = K_WONT;
            got_code  = K_DONT;
         end
      endcase
      nib_new = {got_code, sent_code};
      nib_old = grp_b ? tbl_rd_data[7:4] : tbl_rd_data[3:0];
      send    = naws || (nib_new != nib_old);
   end

   assign produces = (ev.kind != EV_OPT) || send;
   assign done     = busy_ff && rsp_tready && (idx_ff == last_ff);
   assign free     = !busy_ff || done;
   assign take     = ev_valid && (!produces || free);

   // no overlap hazard: IAC and a command byte come first, so the next option byte is read after this write
   assign tbl_wr.we   = take && (ev.kind == EV_OPT) && send;
   assign tbl_wr.addr = ev.val;
   assign tbl_wr.data = grp_b ? {nib_new, tbl_rd_data[3:0]} : {tbl_rd_data[7:4], nib_new};

   assign name_cnt = (term_name_len > 4'(NAME_CHARS)) ? 4'(NAME_CHARS) : term_name_len;

   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      idx_in  = idx_ff;
      last_in = last_ff;
      cmd_in  = cmd_ff;
      val_in  = val_ff;
      if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_tready) begin
         idx_in = idx_ff + 4'd1;
      end
      if (take && produces) begin
         busy_in = 1'b1;
         idx_in  = 4'd0;
         cmd_in  = reply_cmd;
         val_in  = ev.val;
         case (ev.kind)
            EV_DATA: begin
               kind_in = BK_DATA;
               last_in = LAST_DATA;
            end
            EV_TTYPE: begin
               kind_in = BK_TTYPE;
               last_in = TTYPE_FIXED + name_cnt;
            end
            default: begin
               kind_in = naws ? BK_NAWS : BK_ANSWER;
               last_in = naws ? LAST_NAWS : LAST_ANSWER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
      cmd_ff  <= cmd_in;
      val_ff  <= val_in;
   end

   assign name_pos = idx_ff - 4'd4;
   assign name_sel = name_pos[NAME_POS_W-1:0];

   always_comb begin
      rsp_tdata = C_IAC;
      case (kind_ff)
         BK_DATA: rsp_tdata = val_ff;
         BK_ANSWER: begin
            case (idx_ff)
               4'd0:    rsp_tdata = C_IAC;
               4'd1:    rsp_tdata = cmd_ff;
               default: rsp_tdata = val_ff;
            endcase
         end
         BK_NAWS: begin
            case (idx_ff)
               4'd1:    rsp_tdata = C_WILL;
               4'd2:    rsp_tdata = OPT_NAWS;
               4'd4:    rsp_tdata = C_SB;
               4'd5:    rsp_tdata = OPT_NAWS;
               4'd6:    rsp_tdata = window_width[15:8];
               4'd7:    rsp_tdata = window_width[7:0];
               4'd8:    rsp_tdata = window_height[15:8];
               4'd9:    rsp_tdata = window_height[7:0];
               4'd11:   rsp_tdata = C_SE;
               default: rsp_tdata = C_IAC;
            endcase
         end
         default: begin
            if (idx_ff == last_ff) begin
               rsp_tdata = C_SE;
            end else if (idx_ff == last_ff - 4'd1) begin
               rsp_tdata = C_IAC;
            end else begin
               case (idx_ff)
                  4'd0:    rsp_tdata = C_IAC;
                  4'd1:    rsp_tdata = C_SB;
                  4'd2:    rsp_tdata = OPT_TTYPE;
                  4'd3:    rsp_tdata = TTYPE_IS;
                  default: rsp_tdata = term_name[name_sel*8 +: 8];
               endcase
            end
         end
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tuser  = (kind_ff != BK_DATA);
   assign rsp_tlast  = (idx_ff == last_ff);

endmodule
`default_nettype wire

// ===== hdl/telnet_option_negotiator.sv =====
// channel   direction  tdata                   tuser           tlast
// req_      in         rx_byte [7:0]           -               -
// rsp_      out        out_byte [7:0]          dest [0]        last
// csr_      in         write, index [1:0], data [63:0]
//
// plain data and doubled IAC bytes pass at one byte per cycle while rsp_tready holds and no reply burst drains
// a byte's first result transfers after the parser event register and the reply burst registers
// option replies are 3 bytes long, window-size 12, terminal-type 6 to 14
// one byte more is parsed and held while a reply burst drains
// option table read at the option byte's transfer, written at the next edge or once unstalled
// reset needs no clearing pass: per-entry valid bits clear the option table
`default_nettype none
module telnet_option_negotiator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte [7:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte [7:0]
   output logic             rsp_tuser,   // dest [0]
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [63:0] csr_wdata
);
   import otn_pkg::*;

   logic [15:0]   width_ff;
   logic [15:0]   height_ff;
   logic [63:0]   name_ff;
   logic [3:0]    name_len_ff;
   logic          take;
   logic          ev_valid;
   otn_event_type ev;
   logic [7:0]    tbl_rd_data;
   otn_wr_type    tbl_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 16'd80;
         height_ff   <= 16'd24;
         name_ff     <= 64'd0;
         name_len_ff <= 4'd0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_WIDTH:    width_ff    <= csr_wdata[15:0];
            CSR_HEIGHT:   height_ff   <= csr_wdata[15:0];
            CSR_NAME:     name_ff     <= csr_wdata;
            CSR_NAME_LEN: name_len_ff <= csr_wdata[3:0];
            default:      name_len_ff <= name_len_ff;
         endcase
      end
   end

   otn_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .ev_valid   (ev_valid),
      .ev         (ev)
   );

   otn_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_tvalid && req_tready),
      .rd_addr (req_tdata),
      .wr      (tbl_wr),
      .rd_data (tbl_rd_data)
   );

   otn_reply u_reply (
      .clock         (clock),
      .reset         (reset),
      .ev_valid      (ev_valid),
      .ev            (ev),
      .take          (take),
      .tbl_rd_data   (tbl_rd_data),
      .tbl_wr        (tbl_wr),
      .window_width  (width_ff),
      .window_height (height_ff),
      .term_name     (name_ff),
      .term_name_len (name_len_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== hdl/otn_checker.sv =====
`default_nettype none
module otn_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser,
   input wire logic       rsp_tlast
);
   import otn_pkg::*;

   // a stalled transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // terminal bytes are always single results
   a_data_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("terminal byte not marked last");

   // a host reply that follows straight on a finished burst starts with IAC
   a_reply_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=>
         !rsp_tvalid || !rsp_tuser || (rsp_tdata == C_IAC))
      else $error("host reply does not start with IAC");

endmodule

bind telnet_option_negotiator otn_checker u_otn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
